/* rtl/lsar_pkg.sv */
`default_nettype none

package lsar_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [1:0] GainTop   = 2'd3;
  localparam logic [1:0] GainReset = 2'd1;
  localparam logic [2:0] TimeTop   = 3'd5;
  localparam logic [2:0] TimeReset = 3'd2;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgExtreme   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgSaturated = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgVeryLow   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgHigh      = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgLow       = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgInterval  = 3'd5;

  localparam logic [CountWidth-1:0] ExtremeReset   = 16'd60000;
  localparam logic [CountWidth-1:0] SaturatedReset = 16'd50000;
  localparam logic [CountWidth-1:0] VeryLowReset   = 16'd100;
  localparam logic [CountWidth-1:0] HighReset      = 16'd30000;
  localparam logic [CountWidth-1:0] LowReset       = 16'd1000;
  localparam logic [TimeWidth-1:0]  IntervalReset  = 32'd1000;

  typedef enum logic [1:0] {
    PRIO_NONE = 2'd0,
    PRIO_GAIN = 2'd1,
    PRIO_TIME = 2'd2,
    PRIO_BOTH = 2'd3
  } prio_e;

  // large downward jump of integration time on extreme saturation
  function automatic logic [2:0] time_jump_down(input logic [2:0] t);
    logic [2:0] r;
    begin
      if (t > TimeTop) begin
        r = t;
      end else if (t == TimeTop) begin
        r = 3'd2;
      end else if (t == 3'd4) begin
        r = 3'd1;
      end else begin
        r = 3'd0;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/lsar_meas_if.sv */
`default_nettype none

interface lsar_meas_if;
  logic        valid;
  logic        ready;
  logic [15:0] full_count;
  logic [31:0] now_ms;

  modport source (output valid, output full_count, output now_ms, input ready);
  modport sink (input valid, input full_count, input now_ms, output ready);
endinterface

`default_nettype wire

/* rtl/lsar_res_if.sv */
`default_nettype none

interface lsar_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] gain_code;
  logic [2:0] time_code;
  logic       settings_changed;

  modport source (output valid, output gain_code, output time_code,
                  output settings_changed, input ready);
  modport sink (input valid, input gain_code, input time_code,
                input settings_changed, output ready);
endinterface

`default_nettype wire

/* rtl/light_sensor_autorange_core.sv */
`default_nettype none

// channel  | dir | handshake     | payload
// ---------+-----+---------------+-------------------------------------------
// meas     | in  | valid/ready   | full_count[15:0], now_ms[31:0]
// res      | out | valid/ready   | gain_code[1:0], time_code[2:0],
//          |     |               | settings_changed
// cfg      | in  | cfg_we_i only | cfg_idx_i[2:0], cfg_data_i[31:0]
//
// an item is held in the input register and is decided on the edge that loads
// the result register; one item is taken every cycle while the result is not
// stalled; the 32-bit elapsed-time subtract and compare sets the path.
// reset puts gain at step 1, time at step 2 and loads the default thresholds.
// a stalled result holds the input register; the state only moves when an
// item passes into the result register.

module light_sensor_autorange_core
  import lsar_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  lsar_meas_if.sink                    meas,
  lsar_res_if.source                   res,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  // configuration
  logic [CountWidth-1:0] extreme_q, saturated_q, very_low_q, high_q, low_q;
  logic [TimeWidth-1:0]  interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extreme_q   <= ExtremeReset;
      saturated_q <= SaturatedReset;
      very_low_q  <= VeryLowReset;
      high_q      <= HighReset;
      low_q       <= LowReset;
      interval_q  <= IntervalReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgExtreme:   extreme_q   <= cfg_data_i[CountWidth-1:0];
        CfgSaturated: saturated_q <= cfg_data_i[CountWidth-1:0];
        CfgVeryLow:   very_low_q  <= cfg_data_i[CountWidth-1:0];
        CfgHigh:      high_q      <= cfg_data_i[CountWidth-1:0];
        CfgLow:       low_q       <= cfg_data_i[CountWidth-1:0];
        CfgInterval:  interval_q  <= cfg_data_i[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                  in_valid_q;
  logic [CountWidth-1:0] count_q;
  logic [TimeWidth-1:0]  now_q;
  logic                  advance;

  // result register
  logic       res_valid_q;
  logic [1:0] res_gain_q;
  logic [2:0] res_time_q;
  logic       res_changed_q;

  assign advance    = in_valid_q && (!res_valid_q || res.ready);
  assign meas.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (meas.ready) begin
      in_valid_q <= meas.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meas.valid && meas.ready) begin
      count_q <= meas.full_count;
      now_q   <= meas.now_ms;
    end
  end

  // controller state
  logic [1:0]            gain_step_q, gain_step_d;
  logic [2:0]            time_step_q, time_step_d;
  logic [CountWidth-1:0] last_count_q, last_count_d;
  prio_e                 prio_q, prio_d;
  logic [TimeWidth-1:0]  last_change_q, last_change_d;
  logic                  changed;

  logic [TimeWidth-1:0] since;
  logic                 elapsed;
  logic                 gain_prio, time_prio;
  logic                 above_ext;
  logic [1:0]           ng;
  logic [2:0]           nt;
  logic                 fired;

  assign since   = now_q - last_change_q;
  assign elapsed = since >= interval_q;

  always_comb begin
    prio_d       = prio_q;
    last_count_d = last_count_q;
    if (elapsed) begin
      if (count_q == last_count_q) begin
        prio_d = (prio_q == PRIO_GAIN) ? PRIO_TIME : PRIO_GAIN;
      end else begin
        prio_d = PRIO_BOTH;
      end
      last_count_d = count_q;
    end
  end

  assign gain_prio = (prio_d == PRIO_GAIN) || (prio_d == PRIO_BOTH);
  assign time_prio = (prio_d == PRIO_TIME) || (prio_d == PRIO_BOTH);
  assign above_ext = count_q > extreme_q;

  // later rules override earlier ones, all computed from the held settings
  always_comb begin
    ng    = gain_step_q;
    nt    = time_step_q;
    fired = 1'b0;
    if (gain_prio && above_ext && gain_step_q != 2'd0) begin
      ng    = (gain_step_q == GainTop) ? 2'd1 : 2'd0;
      fired = 1'b1;
    end
    if (time_prio && above_ext && time_step_q != 3'd0) begin
      nt    = time_jump_down(time_step_q);
      fired = 1'b1;
    end
    if (count_q > saturated_q && !above_ext) begin
      if (gain_prio) begin
        if (gain_step_q != 2'd0) begin
          ng    = gain_step_q - 2'd1;
          fired = 1'b1;
        end
        if (time_step_q != 3'd0) begin
          nt    = (time_step_q <= TimeTop) ? time_step_q - 3'd1 : time_step_q;
          fired = 1'b1;
        end
      end
    end else if (count_q < very_low_q) begin
      if (time_step_q < TimeTop) begin
        nt    = time_step_q + 3'd1;
        fired = 1'b1;
      end else if (gain_step_q != GainTop) begin
        ng    = gain_step_q + 2'd1;
        fired = 1'b1;
      end
    end else if (count_q > high_q) begin
      if (time_step_q != 3'd0) begin
        nt    = (time_step_q <= TimeTop) ? time_step_q - 3'd1 : time_step_q;
        fired = 1'b1;
      end
    end else if (count_q < low_q) begin
      if (time_step_q < TimeTop) begin
        nt    = time_step_q + 3'd1;
        fired = 1'b1;
      end
    end
  end

  assign changed       = elapsed && fired && (ng != gain_step_q || nt != time_step_q);
  assign gain_step_d   = changed ? ng : gain_step_q;
  assign time_step_d   = changed ? nt : time_step_q;
  assign last_change_d = changed ? now_q : last_change_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_step_q   <= GainReset;
      time_step_q   <= TimeReset;
      last_count_q  <= '0;
      prio_q        <= PRIO_NONE;
      last_change_q <= '0;
    end else if (advance) begin
      gain_step_q   <= gain_step_d;
      time_step_q   <= time_step_d;
      last_count_q  <= last_count_d;
      prio_q        <= prio_d;
      last_change_q <= last_change_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || res.ready) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_gain_q    <= gain_step_d;
      res_time_q    <= time_step_d;
      res_changed_q <= changed;
    end
  end

  assign res.valid            = res_valid_q;
  assign res.gain_code        = res_gain_q;
  assign res.time_code        = res_time_q;
  assign res.settings_changed = res_changed_q;

  // assertions

  // integration time never leaves the six legal steps
  a_time_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_step_q <= TimeTop)
    else $error("time step out of range");

  // a stalled result freezes the controller state
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res.ready |=> $stable(gain_step_q) && $stable(time_step_q)
      && $stable(prio_q) && $stable(last_change_q))
    else $error("state moved while result stalled");

  // the change timestamp only moves together with a flagged result
  a_change_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_change_q) |-> res_valid_q && res_changed_q)
    else $error("timestamp moved without a flagged item");

endmodule

`default_nettype wire
